// ----- hw/rtl/mrr_pkg.sv -----
// Shared constants for the minstd range generator.
`timescale 1ns / 1ps
package mrr_pkg;

  localparam logic [30:0] MINSTD_MOD = 31'h7fffffff;
  localparam logic [15:0] MINSTD_MUL = 16'd48271;
  localparam logic [32:0] SMALL_SPAN = 33'd1000000;
  localparam logic [30:0] FALLBACK_RST = 31'd1;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_RAW   = 2'd1;
  localparam logic [1:0] ACT_RANGE = 2'd2;

  localparam int MUL_W = 16;
  localparam int DVD_W = 62;
  localparam logic [5:0] LEN_SMALL = 6'd31;
  localparam logic [5:0] LEN_BIG   = 6'd62;

  typedef struct packed {
    logic        start;
    logic [30:0] seed;
  } lcg_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] draw;
  } lcg_rsp_t;

  typedef struct packed {
    logic        start;
    logic [61:0] dividend;
    logic [5:0]  len;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ----- hw/rtl/mrr_lcg.sv -----
// Bit-serial modular multiply: seed * 48271 mod (2^31-1), one multiplier bit per cycle.
`timescale 1ns / 1ps
module mrr_lcg (
  input  logic              clk,
  input  logic              rst_n,
  input  mrr_pkg::lcg_req_t req,
  output mrr_pkg::lcg_rsp_t rsp
);

  logic [30:0] acc_r, acc_nxt;
  logic [30:0] s_r, s_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] dbl, dbl_red, sum, sum_red;

  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, mrr_pkg::MINSTD_MOD}) ? dbl - {1'b0, mrr_pkg::MINSTD_MOD} : dbl;
    sum     = {1'b0, dbl_red[30:0]} + (mrr_pkg::MINSTD_MUL[cnt_r] ? {1'b0, s_r} : 32'd0);
    sum_red = (sum >= {1'b0, mrr_pkg::MINSTD_MOD}) ? sum - {1'b0, mrr_pkg::MINSTD_MOD} : sum;

    acc_nxt  = acc_r;
    s_nxt    = s_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      s_nxt    = (req.seed == mrr_pkg::MINSTD_MOD) ? 31'd0 : req.seed;
      cnt_nxt  = 4'(mrr_pkg::MUL_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum_red[30:0];
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    s_r   <= s_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // zero residue maps to the modulus
  assign rsp.done = done_r;
  assign rsp.draw = (acc_r == 31'd0) ? mrr_pkg::MINSTD_MOD : acc_r;

endmodule

// ----- hw/rtl/mrr_div.sv -----
// Bit-serial restoring remainder of a left-aligned dividend by a 33-bit divisor.
`timescale 1ns / 1ps
module mrr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mrr_pkg::div_req_t req,
  output mrr_pkg::div_rsp_t rsp
);

  logic [61:0] dvd_r, dvd_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] t, t_red;

  always_comb begin
    t     = {rem_r, dvd_r[mrr_pkg::DVD_W-1]};
    t_red = (t >= {1'b0, dsr_r}) ? t - {1'b0, dsr_r} : t;

    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.len;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = t_red[32:0];
      dvd_nxt = {dvd_r[mrr_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[31:0];

endmodule

// ----- hw/rtl/minstd_random_range_core.sv -----
// Top level: minstd generator with range draws, item control and output register.
// Set seed and unused codes go straight to the output register. A raw draw runs the
//   16-step serial modular multiply; a range draw with span under 1e6 runs it once and
//   then the 31-step serial remainder, a larger one runs it twice and then the 62-step
//   serial remainder. Throughput: one item at a time; the next item is taken once the
//   previous result is in the output register.
// Synchronous active-low reset: seed 0, fallback seed 1.
`timescale 1ns / 1ps
module minstd_random_range_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // seed_in[31:0], range_from[63:32], range_to[95:64]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // value[31:0], seed_now[62:32], zero[63]
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SPAN  = 7'b0000010,
    S_ABS   = 7'b0000100,
    S_DRAW1 = 7'b0001000,
    S_DRAW2 = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [30:0] seed_r, seed_nxt;
  logic [30:0] fb_r;
  logic [1:0]  act_r, act_nxt;
  logic [31:0] from_r, from_nxt;
  logic [31:0] to_r, to_nxt;
  logic [32:0] diff_r, diff_nxt;
  logic [32:0] span_r, span_nxt;
  logic [30:0] r1_r, r1_nxt;
  logic [31:0] value_r, value_nxt;
  logic        lcg_start_r, lcg_start_nxt;
  logic        div_start_r, div_start_nxt;
  logic [61:0] div_dvd_r, div_dvd_nxt;
  logic [5:0]  div_len_r, div_len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  mrr_pkg::lcg_req_t lcg_req;
  mrr_pkg::lcg_rsp_t lcg_rsp;
  mrr_pkg::div_req_t div_req;
  mrr_pkg::div_rsp_t div_rsp;

  logic in_acc;
  logic neg;

  assign lcg_req.start    = lcg_start_r;
  assign lcg_req.seed     = (seed_r == 31'd0) ? fb_r : seed_r;
  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.len      = div_len_r;
  assign div_req.divisor  = span_r;

  mrr_lcg u_lcg (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (lcg_req),
    .rsp  (lcg_rsp)
  );

  mrr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign neg       = diff_r[32];

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    act_nxt       = act_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    r1_nxt        = r1_r;
    value_nxt     = value_r;
    lcg_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    div_dvd_nxt   = div_dvd_r;
    div_len_nxt   = div_len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_tuser;
          from_nxt  = in_tdata[63:32];
          to_nxt    = in_tdata[95:64];
          value_nxt = '0;
          case (in_tuser)
            mrr_pkg::ACT_SET: begin
              seed_nxt  = in_tdata[30:0];
              state_nxt = S_DONE;
            end
            mrr_pkg::ACT_RAW: begin
              lcg_start_nxt = 1'b1;
              state_nxt     = S_DRAW1;
            end
            mrr_pkg::ACT_RANGE: begin
              state_nxt = S_SPAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SPAN: begin
        diff_nxt  = {to_r[31], to_r} - {from_r[31], from_r};
        state_nxt = S_ABS;
      end
      S_ABS: begin
        // |d| + 1 = ~d + 2 for negative d
        span_nxt      = (neg ? ~diff_r : diff_r) + (neg ? 33'd2 : 33'd1);
        lcg_start_nxt = 1'b1;
        state_nxt     = S_DRAW1;
      end
      S_DRAW1: begin
        if (lcg_rsp.done) begin
          seed_nxt = lcg_rsp.draw;
          if (act_r == mrr_pkg::ACT_RAW) begin
            value_nxt = {1'b0, lcg_rsp.draw};
            state_nxt = S_DONE;
          end else if (span_r < mrr_pkg::SMALL_SPAN) begin
            div_dvd_nxt   = {lcg_rsp.draw, 31'd0};
            div_len_nxt   = mrr_pkg::LEN_SMALL;
            div_start_nxt = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            r1_nxt        = lcg_rsp.draw;
            lcg_start_nxt = 1'b1;
            state_nxt     = S_DRAW2;
          end
        end
      end
      S_DRAW2: begin
        if (lcg_rsp.done) begin
          seed_nxt      = lcg_rsp.draw;
          div_dvd_nxt   = {r1_r, lcg_rsp.draw};
          div_len_nxt   = mrr_pkg::LEN_BIG;
          div_start_nxt = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          value_nxt = from_r + div_rsp.rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, seed_r, value_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    diff_r     <= diff_nxt;
    span_r     <= span_nxt;
    r1_r       <= r1_nxt;
    value_r    <= value_nxt;
    div_dvd_r  <= div_dvd_nxt;
    div_len_r  <= div_len_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= '0;
      fb_r        <= mrr_pkg::FALLBACK_RST;
      lcg_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      fb_r        <= cfg_we ? cfg_wdata : fb_r;
      lcg_start_r <= lcg_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- test/minstd_random_range_core_tb.sv -----
// Self-checking testbench for minstd_random_range_core: seed loads, raw and ranged draws.
`timescale 1ns / 1ps
module minstd_random_range_core_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 280;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seed_in;
    logic [31:0] range_from;
    logic [31:0] range_to;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [30:0] seed_now;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // seed_in[31:0], range_from[63:32], range_to[95:64]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // value[31:0], seed_now[62:32], zero[63]

  minstd_random_range_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [30:0] model_seed = '0;
  logic [30:0] model_fallback = mrr_pkg::FALLBACK_RST;

  req_t  items_todo[$];
  draw_t draws_due[$];
  req_t  on_wire;

  int errors = 0;
  int results_seen = 0;
  int n_loads = 0, n_raw = 0, n_small = 0, n_wide = 0, n_unused = 0;
  int n_cfg = 0, n_holds = 0;

  function automatic logic [30:0] advance_seed();
    logic [63:0] prod;
    logic [63:0] nxt;
    if (model_seed == '0) model_seed = model_fallback;
    prod = {33'd0, model_seed} * {48'd0, mrr_pkg::MINSTD_MUL};
    nxt = prod % {33'd0, mrr_pkg::MINSTD_MOD};
    if (nxt == '0) nxt = {33'd0, mrr_pkg::MINSTD_MOD};
    model_seed = nxt[30:0];
    return nxt[30:0];
  endfunction

  function automatic draw_t minstd_step(input req_t r);
    draw_t d;
    logic signed [63:0] from_w;
    logic signed [63:0] to_w;
    logic signed [63:0] diff;
    logic [63:0] span, rem, r1, r2;
    d.value = '0;
    case (r.action)
      mrr_pkg::ACT_SET: begin
        model_seed = r.seed_in[30:0];
        n_loads++;
      end
      mrr_pkg::ACT_RAW: begin
        d.value = {1'b0, advance_seed()};
        n_raw++;
      end
      mrr_pkg::ACT_RANGE: begin
        from_w = {{32{r.range_from[31]}}, r.range_from};
        to_w = {{32{r.range_to[31]}}, r.range_to};
        diff = to_w - from_w;
        span = (diff < 0) ? -diff + 1 : diff + 1;
        if (span < {31'd0, mrr_pkg::SMALL_SPAN}) begin
          r1 = {33'd0, advance_seed()};
          rem = r1 % span;
          n_small++;
        end else begin
          r1 = {33'd0, advance_seed()};
          r2 = {33'd0, advance_seed()};
          rem = ((r1 << 31) | r2) % span;
          n_wide++;
        end
        d.value = r.range_from + rem[31:0];
      end
      default: n_unused++;
    endcase
    d.seed_now = model_seed;
    return d;
  endfunction

  function automatic req_t make_req(input logic [1:0] act, input logic [31:0] s,
                                    input logic [31:0] f, input logic [31:0] t);
    req_t r;
    r.action = act;
    r.seed_in = s;
    r.range_from = f;
    r.range_to = t;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int unsigned pick;
    logic [31:0] off;
    logic [31:0] ends[4];
    ends = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    r.seed_in = $urandom;
    r.range_from = $urandom;
    r.range_to = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.action = mrr_pkg::ACT_SET;
      case ($urandom_range(0, 5))
        0: r.seed_in = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
        1: r.seed_in = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'hffff_ffff;
        2: r.seed_in = $urandom_range(1, 100);
        default: ;
      endcase
    end else if (pick < 37) begin
      r.action = mrr_pkg::ACT_RAW;
    end else if (pick < 95) begin
      r.action = mrr_pkg::ACT_RANGE;
      case ($urandom_range(0, 5))
        0, 1: off = $urandom_range(0, 999998);
        2: off = $urandom_range(0, 100);
        3: off = 32'd999998 + $urandom_range(0, 2);
        default: off = '0;
      endcase
      if ($urandom_range(0, 5) < 4) begin
        r.range_to = $urandom_range(0, 1) ? r.range_from + off : r.range_from - off;
      end else if ($urandom_range(0, 1)) begin
        r.range_from = ends[$urandom_range(0, 3)];
        r.range_to = ends[$urandom_range(0, 3)];
      end
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_result();
    draw_t want;
    if (draws_due.size() == 0) begin
      report_mismatch($sformatf("result %h with no item pending", out_tdata));
    end else begin
      want = draws_due.pop_front();
      if (out_tdata[31:0] !== want.value)
        report_mismatch($sformatf("item %0d value %h, want %h",
                                  results_seen, out_tdata[31:0], want.value));
      if (out_tdata[62:32] !== want.seed_now)
        report_mismatch($sformatf("item %0d seed_now %h, want %h",
                                  results_seen, out_tdata[62:32], want.seed_now));
    end
    results_seen++;
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) draws_due.push_back(minstd_step(on_wire));
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (items_todo.size() > 0) begin
        on_wire = items_todo.pop_front();
        in_tuser <= on_wire.action;
        in_tdata <= {on_wire.range_to, on_wire.range_from, on_wire.seed_in};
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0: begin
              burst_left = $urandom_range(30, 80);
              gap_left = 0;
            end
            1: begin
              burst_left = $urandom_range(1, 6);
              gap_left = $urandom_range(40, 120);
            end
            default: begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(0, 40);
            end
          endcase
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: checks results, stalls on its own pattern, two long hold-offs
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 200;
  logic ready_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (results_seen == next_hold_at) begin
        hold_left = $urandom_range(300, 500);
        next_hold_at += 1000;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (stall_mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_tready <= ready_next;
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (!(items_todo.size() == 0 && !in_tvalid && draws_due.size() == 0));
  endtask

  task automatic write_fallback(input logic [30:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_fallback = v;
    n_cfg++;
  endtask

  logic [30:0] fallbacks[6];

  initial begin
    fallbacks = '{31'd0, 31'd2147483646, 31'h7fff_ffff, 31'd0, 31'd0, mrr_pkg::FALLBACK_RST};
    fallbacks[3] = 31'($urandom);
    fallbacks[4] = 31'($urandom_range(1, 1000));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero seed takes fallback; all-ones seed sticks; span edges and wraps
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'hffff_ffff, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h8000_0001, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, -32'sd5, 32'sd5));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'sd10, -32'sd10));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'd0, 32'd999998));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'd0, 32'd999999));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'd999999, 32'd0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h7fff_ffff, 32'h8000_0000));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h7fff_ffff, 32'h7fff_fff5));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h8000_0000, 32'h8000_0005));
    items_todo.push_back(make_req(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h1234_5678, 32'h0, 32'h0));
    items_todo.push_back(make_req(ACT_UNUSED, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h7fff_ff00, 32'h7fff_ffff));
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h0, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, -32'sd1000, 32'sd1000));
    items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h8000_0000, 32'h0, 32'h0));
    items_todo.push_back(make_req(mrr_pkg::ACT_RANGE, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    items_todo.push_back(make_req(mrr_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0));

    foreach (fallbacks[i]) begin
      write_fallback(fallbacks[i]);
      items_todo.push_back(make_req(mrr_pkg::ACT_SET, 32'h0, 32'h0, 32'h0));
      items_todo.push_back(make_req(mrr_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0));
      repeat (PHASE_ITEMS) items_todo.push_back(random_req());
    end

    drain();
    repeat (200) @(posedge clk);
    while (draws_due.size() > 0) begin
      void'(draws_due.pop_front());
      report_mismatch("result never arrived");
    end

    $display("covered %0d seed loads, %0d raw draws, %0d narrow and %0d wide range draws,",
             n_loads, n_raw, n_small, n_wide);
    $display("  %0d unused codes, %0d fallback settings, %0d long output stalls; %0d errors",
             n_unused, n_cfg, n_holds, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
